// File: rtl/core/zoomed_sprite_tile_expander_macros.svh
// Assertion helpers for the sprite tile expander
`ifndef ZOOMED_SPRITE_TILE_EXPANDER_MACROS_SVH
`define ZOOMED_SPRITE_TILE_EXPANDER_MACROS_SVH

// implication checked on every clock, off during reset
`define ZSTE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ZSTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/zste_pkg.sv
`default_nettype none
package zste_pkg;

    // recip = RecipNum / zoom
    localparam int unsigned RecipNum = 32'h0080_0000;
    localparam int RecipW = 24;
    localparam int ZoomW = 10;
    localparam int PosW = 14;
    localparam int StepW = 11;

    // register indexes
    localparam logic [1:0] REG_BANK_LIMIT = 2'd0;
    localparam logic [1:0] REG_FLIP_SCREEN = 2'd1;
    localparam logic [1:0] REG_WRAP_COPY = 2'd2;

    // decoded sprite handed from front to back
    typedef struct packed {
        logic [15:0] code;
        logic [15:0] bank;
        logic [7:0] color;
        logic signed [PosW-1:0] ox;
        logic signed [PosW-1:0] oy;
        logic mx;
        logic my;
        logic [2:0] w;
        logic [2:0] h;
        logic [RecipW-1:0] recip;
    } job_t;

    // output command
    typedef struct packed {
        logic last;
        logic [StepW-1:0] step_h;
        logic [StepW-1:0] step_w;
        logic my;
        logic mx;
        logic signed [PosW-1:0] pos_y;
        logic signed [PosW-1:0] pos_x;
        logic [7:0] color;
        logic [15:0] code;
    } cmd_t;

    function automatic logic [3:0] col_off(input logic [1:0] i);
        case (i)
            2'd0: col_off = 4'd0;
            2'd1: col_off = 4'd1;
            2'd2: col_off = 4'd4;
            default: col_off = 4'd5;
        endcase
    endfunction

    function automatic logic [3:0] row_off(input logic [1:0] i);
        case (i)
            2'd0: row_off = 4'd0;
            2'd1: row_off = 4'd2;
            2'd2: row_off = 4'd8;
            default: row_off = 4'd10;
        endcase
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/zste_front.sv
`default_nettype none
// Accepts a sprite entry, divides for the reciprocal (one quotient bit a
// cycle), decodes size, bank and flips, then hands a job to the queue.
module zste_front (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_ready,
    input wire logic [7:0] y_byte,
    input wire logic [15:0] sprite_code,
    input wire logic [7:0] sprite_color,
    input wire logic [7:0] x_low,
    input wire logic [7:0] attr_byte,
    input wire logic [7:0] zoom_low,
    input wire logic [15:0] bank_limit,
    input wire logic flip_screen,
    output logic job_valid,
    input wire logic job_ready,
    output zste_pkg::job_t job
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV = 2'd1;
    localparam logic [1:0] ST_FLIP = 2'd2;
    localparam logic [1:0] ST_OUT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [4:0] cnt_reg;
    logic [zste_pkg::ZoomW:0] rem_reg;
    logic [zste_pkg::ZoomW-1:0] zoom_reg;
    logic [23:0] num_reg;
    zste_pkg::job_t job_reg;
    logic [zste_pkg::ZoomW:0] rem_sh;
    logic [zste_pkg::ZoomW-1:0] zoom_in;
    logic [2:0] w_dec, h_dec;
    logic [15:0] code_al;
    logic [26:0] pw, ph;
    logic [13:0] sw_n, sh_n;

    assign zoom_in = {attr_byte[1:0], zoom_low};
    assign rem_sh = {rem_reg[zste_pkg::ZoomW-1:0], num_reg[23]};
    assign in_ready = (state_reg == ST_IDLE);
    assign job_valid = (state_reg == ST_OUT);
    assign job = job_reg;

    // size decode
    always_comb
    begin
        code_al = sprite_code & bank_limit;
        w_dec = 3'd1;
        h_dec = 3'd1;
        case (attr_byte[6:4])
            3'd2:
            begin
                w_dec = 3'd2;
                code_al[0] = 1'b0;
            end
            3'd1:
            begin
                h_dec = 3'd2;
                code_al[1] = 1'b0;
            end
            3'd0:
            begin
                w_dec = 3'd2;
                h_dec = 3'd2;
                code_al[1:0] = 2'b00;
            end
            3'd4:
            begin
                w_dec = 3'd4;
                h_dec = 3'd4;
                code_al[1:0] = 2'b00;
            end
            default:
            begin
                w_dec = 3'd1;
            end
        endcase
    end

    // screen flip extents
    assign pw = job_reg.recip * job_reg.w;
    assign ph = job_reg.recip * job_reg.h;
    assign sw_n = pw[26:13] + {13'd0, pw[12]};
    assign sh_n = ph[26:13] + {13'd0, ph[12]};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid && zoom_in != '0) state_next = ST_DIV;
            ST_DIV: if (cnt_reg == 5'd23) state_next = ST_FLIP;
            ST_FLIP: state_next = ST_OUT;
            ST_OUT: if (job_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cnt_reg <= '0;
                rem_reg <= '0;
                num_reg <= 24'h80_0000;
                zoom_reg <= zoom_in;
                job_reg.code <= code_al;
                job_reg.bank <= sprite_code & ~bank_limit;
                job_reg.color <= sprite_color;
                job_reg.ox <= {{6{attr_byte[7]}}, x_low};
                job_reg.oy <= 14'sd256 - {6'd0, y_byte};
                job_reg.mx <= attr_byte[2];
                job_reg.my <= attr_byte[3];
                job_reg.w <= w_dec;
                job_reg.h <= h_dec;
            end
            ST_DIV:
            begin
                cnt_reg <= cnt_reg + 5'd1;
                num_reg <= {num_reg[22:0], 1'b0};
                if (rem_sh >= {1'b0, zoom_reg})
                begin
                    rem_reg <= rem_sh - {1'b0, zoom_reg};
                    job_reg.recip <= {job_reg.recip[22:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    job_reg.recip <= {job_reg.recip[22:0], 1'b0};
                end
            end
            ST_FLIP:
            begin
                if (flip_screen)
                begin
                    job_reg.ox <= 14'sd256 - job_reg.ox - $signed(sw_n);
                    job_reg.oy <= 14'sd256 - job_reg.oy - $signed(sh_n);
                    job_reg.mx <= ~job_reg.mx;
                    job_reg.my <= ~job_reg.my;
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/core/zste_queue.sv
`default_nettype none
// Two-entry job queue between front and back.
module zste_queue (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic wr_valid,
    output logic wr_ready,
    input wire zste_pkg::job_t wr_job,
    output logic rd_valid,
    input wire logic rd_ready,
    output zste_pkg::job_t rd_job
);
    zste_pkg::job_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_job = mem_reg[rp_reg];
    assign do_wr = wr_valid && wr_ready;
    assign do_rd = rd_valid && rd_ready;

    // pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr) wp_reg <= ~wp_reg;
            if (do_rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) mem_reg[wp_reg] <= wr_job;
    end
endmodule
`default_nettype wire

// File: rtl/core/zste_back.sv
`default_nettype none
// Walks the tile grid of a job, one grid step (tile or its copy) per cycle unless
// the output is stalled, with scaled offsets multiplied out from the reciprocal; output register holds one command.
module zste_back (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic job_valid,
    output logic job_ready,
    input wire zste_pkg::job_t job,
    input wire logic [15:0] bank_limit,
    input wire logic wrap_copy,
    output logic out_valid,
    input wire logic out_ready,
    output zste_pkg::cmd_t out_cmd
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN = 2'd1;

    logic [1:0] state_reg;
    zste_pkg::job_t j_reg;
    logic [1:0] x_reg, y_reg;
    logic copy_reg;
    // pending command (found, not yet pushed)
    logic hold_valid_reg;
    zste_pkg::cmd_t hold_reg;
    logic outv_reg;
    zste_pkg::cmd_t out_reg;

    logic [26:0] ax0, ax1, ay0, ay1;
    logic [13:0] sx0, sx1, sy0, sy1;
    logic [1:0] cx, cy;
    logic [16:0] c_sum;
    logic drop;
    logic last_x, last_y, last_cell;
    zste_pkg::cmd_t cur;
    zste_pkg::cmd_t flush_cmd;
    logic can_push, step;
    logic adv_hold, flush;

    // scaled offsets of current column and row
    assign ax0 = j_reg.recip * {1'b0, x_reg};
    assign ax1 = j_reg.recip * ({1'b0, x_reg} + 3'd1);
    assign ay0 = j_reg.recip * {1'b0, y_reg};
    assign ay1 = j_reg.recip * ({1'b0, y_reg} + 3'd1);
    assign sx0 = ax0[26:13] + {13'd0, ax0[12]};
    assign sx1 = ax1[26:13] + {13'd0, ax1[12]};
    assign sy0 = ay0[26:13] + {13'd0, ay0[12]};
    assign sy1 = ay1[26:13] + {13'd0, ay1[12]};

    assign cx = j_reg.mx ? (j_reg.w[1:0] - 2'd1 - x_reg) : x_reg;
    assign cy = j_reg.my ? (j_reg.h[1:0] - 2'd1 - y_reg) : y_reg;
    assign c_sum = {1'b0, j_reg.code} + {13'd0, zste_pkg::col_off(cx)}
        + {13'd0, zste_pkg::row_off(cy)};
    assign drop = c_sum[16] || ((c_sum[15:0] & ~bank_limit) != 16'd0);

    // a dropped final cell has no copy, so it also ends the grid
    assign last_x = ({1'b0, x_reg} == j_reg.w - 3'd1);
    assign last_y = ({1'b0, y_reg} == j_reg.h - 3'd1);
    assign last_cell = last_x && last_y && (copy_reg || !wrap_copy || drop);

    always_comb
    begin
        cur.code = c_sum[15:0] + j_reg.bank;
        cur.color = j_reg.color;
        cur.pos_x = j_reg.ox + $signed(sx0);
        cur.pos_y = j_reg.oy + $signed(sy0) - (copy_reg ? 14'sd256 : 14'sd0);
        cur.mx = j_reg.mx;
        cur.my = j_reg.my;
        cur.step_w = sx1[10:0] - sx0[10:0];
        cur.step_h = sy1[10:0] - sy0[10:0];
        cur.last = 1'b0;
    end

    // held command marked as the final one of its sprite
    always_comb
    begin
        flush_cmd = hold_reg;
        flush_cmd.last = 1'b1;
    end

    // hold stage waits one step so last can be set on the final command
    assign can_push = !outv_reg || out_ready;
    assign step = (state_reg == ST_RUN) && (!hold_valid_reg || drop || can_push);
    assign adv_hold = step && !drop && hold_valid_reg;
    assign flush = (state_reg == ST_IDLE) && hold_valid_reg && can_push;
    assign job_ready = (state_reg == ST_IDLE) && !hold_valid_reg;
    assign out_valid = outv_reg;
    assign out_cmd = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hold_valid_reg <= 1'b0;
            outv_reg <= 1'b0;
            x_reg <= '0;
            y_reg <= '0;
            copy_reg <= 1'b0;
        end
        else
        begin
            if (adv_hold || flush) outv_reg <= 1'b1;
            else if (out_ready) outv_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid && job_ready)
                    begin
                        state_reg <= ST_RUN;
                        x_reg <= '0;
                        y_reg <= '0;
                        copy_reg <= 1'b0;
                    end
                end
                ST_RUN:
                begin
                    if (step)
                    begin
                        if (!drop)
                        begin
                            hold_valid_reg <= 1'b1;
                        end
                        if (last_cell)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        if (wrap_copy && !copy_reg && !drop)
                        begin
                            copy_reg <= 1'b1;
                        end
                        else
                        begin
                            copy_reg <= 1'b0;
                            if (last_x)
                            begin
                                x_reg <= '0;
                                y_reg <= y_reg + 2'd1;
                            end
                            else
                            begin
                                x_reg <= x_reg + 2'd1;
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            // flush the held command as last once the grid is done
            if (flush)
            begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && job_valid && job_ready) j_reg <= job;
        if (step && !drop) hold_reg <= cur;
        if (adv_hold) out_reg <= hold_reg;
        if (flush) out_reg <= flush_cmd;
    end
endmodule
`default_nettype wire

// File: rtl/core/zoomed_sprite_tile_expander.sv
`default_nettype none
// Channel   Dir  Contents
// s_axis    in   sprite entry: tdata = y_byte, sprite_code, sprite_color, x_low,
//                attr_byte, zoom_low
// m_axis    out  tile command: tdata = tile_code .. step_h, tlast = last
// cfg       in   bank_limit, flip_screen, wrap_copy
// Front: accept, restoring division (one quotient bit a cycle), flip and handoff
// states per sprite. Back: pickup, then one tile or copy per cycle (up to 32) unless
// m_axis stalls, then a flush of the final command. 2-deep queue between.
// Reset clears configuration, queue and control state. Stalls on m_axis
// hold the back part; the front continues until the queue is full.
module zoomed_sprite_tile_expander (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_axis_tvalid,
    output logic s_axis_tready,
    // y_byte[7:0], sprite_code[23:8], sprite_color[31:24], x_low[39:32],
    // attr_byte[47:40], zoom_low[55:48]
    input wire logic [55:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input wire logic m_axis_tready,
    // tile_code[15:0], tile_color[23:16], pos_x[37:24], pos_y[51:38],
    // mirror_x[52], mirror_y[53], step_w[64:54], step_h[75:65], zero pad
    output logic [79:0] m_axis_tdata,
    output logic m_axis_tlast,
    input wire logic cfg_we,
    input wire logic [1:0] cfg_index,
    input wire logic [15:0] cfg_data
);
    logic [15:0] bank_limit_reg;
    logic flip_screen_reg, wrap_copy_reg;
    logic fq_valid, fq_ready, qb_valid, qb_ready;
    zste_pkg::job_t fq_job, qb_job;
    zste_pkg::cmd_t cmd;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_limit_reg <= '0;
            flip_screen_reg <= 1'b0;
            wrap_copy_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                zste_pkg::REG_BANK_LIMIT: bank_limit_reg <= cfg_data;
                zste_pkg::REG_FLIP_SCREEN: flip_screen_reg <= cfg_data[0];
                zste_pkg::REG_WRAP_COPY: wrap_copy_reg <= cfg_data[0];
                default: bank_limit_reg <= bank_limit_reg;
            endcase
        end
    end

    zste_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .y_byte(s_axis_tdata[7:0]), .sprite_code(s_axis_tdata[23:8]),
        .sprite_color(s_axis_tdata[31:24]), .x_low(s_axis_tdata[39:32]),
        .attr_byte(s_axis_tdata[47:40]), .zoom_low(s_axis_tdata[55:48]),
        .bank_limit(bank_limit_reg), .flip_screen(flip_screen_reg),
        .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
    );

    zste_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_job(fq_job),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_job(qb_job)
    );

    zste_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
        .bank_limit(bank_limit_reg), .wrap_copy(wrap_copy_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_cmd(cmd)
    );

    assign m_axis_tdata = {4'd0, cmd.step_h, cmd.step_w, cmd.my, cmd.mx,
        cmd.pos_y, cmd.pos_x, cmd.color, cmd.code};
    assign m_axis_tlast = cmd.last;

`include "zoomed_sprite_tile_expander_macros.svh"

    `ZSTE_ASSERT_NEXT(a_hold_out, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `ZSTE_ASSERT_NEXT(a_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `ZSTE_ASSERT_IMPL(a_front_busy, fq_valid, !s_axis_tready)

endmodule
`default_nettype wire

// File: test/zste_checker.sv
`timescale 1ns / 100ps
module zste_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [79:0] m_axis_tdata,
    input  wire logic        m_axis_tlast,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output int               fail_count,
    output int               pending_tiles
);
    // expected command: 80-bit tdata plus last flag
    typedef struct packed {
        logic [79:0] data;
        logic        last;
    } tile_exp_t;

    tile_exp_t tile_queue[$];
    logic [15:0] bank_limit_q;
    logic flip_q;
    logic wrap_q;

    assign pending_tiles = tile_queue.size();

    function automatic int unsigned scale_pos(int unsigned recip, int unsigned k);
        longint unsigned p;
        p = (longint'(recip) * k + 64'h1000) >> 13;
        return int'(p);
    endfunction

    function automatic logic [79:0] pack_tile(logic [15:0] c, logic [7:0] col,
        int px, int py, logic mx, logic my, int sw, int sh);
        logic [79:0] d;
        d = '0;
        d[15:0]  = c;
        d[23:16] = col;
        d[37:24] = px[13:0];
        d[51:38] = py[13:0];
        d[52]    = mx;
        d[53]    = my;
        d[64:54] = sw[10:0];
        d[75:65] = sh[10:0];
        return d;
    endfunction

    // expand one sprite entry into expected tile commands
    task automatic expand_sprite(logic [55:0] e);
        logic [7:0] yb, col, xl, attr, zl;
        logic [15:0] code, bank, mask_inv;
        logic [31:0] cs;
        int ox, oy, w, h, sx, sy, sw, sh, n, first;
        int unsigned zoom, recip;
        logic mx, my;
        tile_exp_t t;
        yb = e[7:0]; code = e[23:8]; col = e[31:24];
        xl = e[39:32]; attr = e[47:40]; zl = e[55:48];
        mask_inv = ~bank_limit_q;
        ox = int'(xl) - (attr[7] ? 256 : 0);
        oy = 256 - int'(yb);
        mx = attr[2]; my = attr[3];
        bank = code & mask_inv;
        code = code & bank_limit_q;
        zoom = {attr[1:0], zl};
        if (zoom == 0) return;
        recip = zste_pkg::RecipNum / zoom;
        case (attr[6:4])
            3'd0: begin w = 2; h = 2; code[1:0] = 2'b00; end
            3'd1: begin w = 1; h = 2; code[1] = 1'b0; end
            3'd2: begin w = 2; h = 1; code[0] = 1'b0; end
            3'd4: begin w = 4; h = 4; code[1:0] = 2'b00; end
            default: begin w = 1; h = 1; end
        endcase
        if (flip_q) begin
            ox = 256 - ox - int'(scale_pos(recip, w));
            oy = 256 - oy - int'(scale_pos(recip, h));
            mx = ~mx; my = ~my;
        end
        n = 0;
        first = tile_queue.size();
        for (int y = 0; y < h; y++) begin
            sy = oy + int'(scale_pos(recip, y));
            sh = oy + int'(scale_pos(recip, y + 1)) - sy;
            for (int x = 0; x < w; x++) begin
                sx = ox + int'(scale_pos(recip, x));
                sw = ox + int'(scale_pos(recip, x + 1)) - sx;
                cs = 32'(code);
                cs += mx ? zste_pkg::col_off(2'(w - 1 - x)) : zste_pkg::col_off(2'(x));
                cs += my ? zste_pkg::row_off(2'(h - 1 - y)) : zste_pkg::row_off(2'(y));
                if ((cs & ~32'(bank_limit_q)) != 0) continue;
                cs += 32'(bank);
                if (n < 32) begin
                    t.data = pack_tile(cs[15:0], col, sx, sy, mx, my, sw, sh);
                    t.last = 1'b0;
                    tile_queue.push_back(t);
                    n++;
                end
                if (wrap_q && n < 32) begin
                    t.data = pack_tile(cs[15:0], col, sx, sy - 256, mx, my, sw, sh);
                    t.last = 1'b0;
                    tile_queue.push_back(t);
                    n++;
                end
            end
        end
        if (n > 0) tile_queue[tile_queue.size() - 1].last = 1'b1;
    endtask

    // track registers, predict on input transfer, compare on output transfer
    always @(posedge clk or negedge rst_n)
    begin
        tile_exp_t want;
        if (!rst_n)
        begin
            bank_limit_q <= '0;
            flip_q <= 1'b0;
            wrap_q <= 1'b0;
            fail_count <= 0;
            tile_queue.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    zste_pkg::REG_BANK_LIMIT: bank_limit_q <= cfg_data;
                    zste_pkg::REG_FLIP_SCREEN: flip_q <= cfg_data[0];
                    zste_pkg::REG_WRAP_COPY: wrap_q <= cfg_data[0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expand_sprite(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (tile_queue.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected tile command %h last %b",
                                 m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    want = tile_queue.pop_front();
                    if (want.data !== m_axis_tdata || want.last !== m_axis_tlast)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("tile mismatch: expected %h last %b, got %h last %b",
                                     want.data, want.last, m_axis_tdata, m_axis_tlast);
                    end
                end
            end
        end
    end
endmodule

// File: test/tb_zoomed_sprite_tile_expander.sv
`timescale 1ns / 100ps
module tb_zoomed_sprite_tile_expander;
    localparam int IdleLimit = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // y_byte, sprite_code, sprite_color, x_low, attr_byte, zoom_low
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // tile_code, tile_color, pos_x, pos_y, mirror_x, mirror_y, step_w, step_h
    logic [79:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending_tiles;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          quiet_cycles;

    zoomed_sprite_tile_expander DUT (.*);

    zste_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stalls
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IdleLimit)
        begin
            $display("tb_zoomed_sprite_tile_expander: FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // one sprite entry transfer, with optional sender gap first
    task automatic send_sprite(logic [7:0] yb, logic [15:0] code, logic [7:0] col,
                               logic [7:0] xl, logic [7:0] attr, logic [7:0] zl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {zl, attr, xl, col, code, yb};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_tiles();
        s_axis_tvalid <= 1'b0;
        while (pending_tiles != 0) @(negedge clk);
        // a sprite yielding no tiles may still be in flight
        repeat (80) @(negedge clk);
    endtask

    function automatic logic [7:0] pick_zoom_low(logic [1:0] zh);
        case ($urandom_range(5))
            0: return 8'h80;
            1: return 8'($urandom_range(255));
            2: return 8'($urandom_range(32, 255));
            3: return (zh == 0) ? 8'($urandom_range(1, 8)) : 8'($urandom_range(255));
            default: return 8'($urandom_range(64, 192));
        endcase
    endfunction

    task automatic random_sprites(int count);
        logic [7:0] attr;
        for (int i = 0; i < count; i++)
        begin
            attr = 8'($urandom_range(255));
            if ($urandom_range(3) != 0) attr[1:0] = 2'b00;
            send_sprite(8'($urandom_range(255)), 16'($urandom_range(65535)),
                        8'($urandom_range(255)), 8'($urandom_range(255)), attr,
                        pick_zoom_low(attr[1:0]));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = zste_pkg::REG_BANK_LIMIT;
        cfg_data = '0;
        send_idle_pct = 12;
        recv_idle_pct = 47;
        quiet_cycles = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: bank_limit zero drops every tile with a nonzero offset
        send_sprite(8'h10, 16'h1234, 8'h55, 8'h20, 8'h00, 8'h80);
        drain_tiles();
        write_reg(zste_pkg::REG_BANK_LIMIT, 16'hFFFF);
        // every size, flip, zoom extremes, x sign
        for (int s = 0; s < 8; s++)
            send_sprite(8'($urandom_range(255)), 16'hFFFF, 8'hA5, 8'hFF,
                        {1'b1, 3'(s), 2'(s), 2'b00}, 8'h80);
        send_sprite(8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
        send_sprite(8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_sprite(8'h80, 16'h00F0, 8'h12, 8'h40, 8'h43, 8'hFF);
        send_sprite(8'h80, 16'h00F0, 8'h12, 8'h40, 8'h40, 8'h01);
        send_sprite(8'h01, 16'h8001, 8'h34, 8'h00, 8'h4C, 8'h40);
        drain_tiles();
        // narrow bank: overflowing tiles dropped, bank bits kept
        write_reg(zste_pkg::REG_BANK_LIMIT, 16'h000F);
        send_sprite(8'h30, 16'hABCC, 8'h01, 8'h10, 8'h40, 8'h80);
        send_sprite(8'h30, 16'hABC4, 8'h01, 8'h10, 8'h00, 8'h80);
        drain_tiles();
        write_reg(zste_pkg::REG_FLIP_SCREEN, 16'hFFFF);
        write_reg(zste_pkg::REG_WRAP_COPY, 16'h0001);
        write_reg(2'd3, 16'h0000);
        write_reg(zste_pkg::REG_BANK_LIMIT, 16'hFFFF);
        send_sprite(8'h20, 16'h0100, 8'h77, 8'hF0, 8'hC0, 8'h80);
        send_sprite(8'h20, 16'h0100, 8'h77, 8'hF0, 8'h4D, 8'h20);
        drain_tiles();

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 2) begin send_idle_pct = 47; recv_idle_pct = 12; end
            if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
            write_reg(zste_pkg::REG_BANK_LIMIT, (ph % 3 == 0) ? 16'hFFFF :
                      (ph % 3 == 1) ? 16'($urandom_range(65535)) : 16'h03FF);
            write_reg(zste_pkg::REG_FLIP_SCREEN, 16'(ph & 1));
            write_reg(zste_pkg::REG_WRAP_COPY, 16'((ph >> 1) & 1));
            random_sprites(42);
            drain_tiles();
        end

        if (fail_count == 0)
            $display("tb_zoomed_sprite_tile_expander: PASS");
        else
            $display("tb_zoomed_sprite_tile_expander: FAIL");
        $finish;
    end
endmodule
